// ===== design/bcmp_pkg.sv =====
// ----------------------------------------------------------------------------
// bcmp_pkg
// Shared constants and types for the binomial coefficient modulo prime block.
// ----------------------------------------------------------------------------
package bcmp_pkg;

   // field widths
   localparam int QW = 12;
   localparam int CW = 30;

   // modulus and Barrett reduction constants (mu = floor(2^60 / p))
   localparam logic [29:0] PRIME_MOD  = 30'd1000000007;
   localparam logic [30:0] BARRETT_MU = 31'd1152921496;
   localparam logic [31:0] PRIME_X2   = 32'd2000000014;
   localparam logic [29:0] FERMAT_EXP = 30'd1000000005;

   // modular multiplier latency in cycles
   localparam int MUL_LAT = 4;

   // default table depth
   localparam int DEF_TABLE_SIZE = 4096;

   // build sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_FACT_MUL,
      ST_FACT_WAIT,
      ST_POW_MUL,
      ST_POW_WAIT,
      ST_INV_MUL,
      ST_INV_WAIT,
      ST_DONE
   } bld_state_type;

endpackage

// ===== design/bcmp_modmul.sv =====
// ----------------------------------------------------------------------------
// bcmp_modmul
// Pipelined a*b mod p with Barrett reduction.
// ----------------------------------------------------------------------------
module bcmp_modmul
   import bcmp_pkg::*;
(
   input  logic          clock,
   input  logic [CW-1:0] op_a,
   input  logic [CW-1:0] op_b,
   output logic [CW-1:0] result
);

   logic [59:0] prod_ff;
   logic [59:0] prod_in;
   logic [61:0] q2;
   logic [30:0] q3_ff;
   logic [31:0] low_ff;
   logic [60:0] qp;
   logic [31:0] rem_ff;
   logic [31:0] rem_in;
   logic [CW-1:0] res_ff;
   logic [CW-1:0] res_in;

   // full product
   assign prod_in = op_a * op_b;

   // quotient estimate
   assign q2 = prod_ff[59:29] * BARRETT_MU;

   // remainder below three times p
   assign qp     = q3_ff * PRIME_MOD;
   assign rem_in = low_ff - qp[31:0];

   // final correction
   always_comb begin
      if (rem_ff >= PRIME_X2) begin
         res_in = CW'(rem_ff - PRIME_X2);
      end else if (rem_ff >= 32'(PRIME_MOD)) begin
         res_in = CW'(rem_ff - 32'(PRIME_MOD));
      end else begin
         res_in = CW'(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      q3_ff   <= q2[61:31];
      low_ff  <= prod_ff[31:0];
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign result = res_ff;

endmodule

// ===== design/binomial_coefficient_mod_prime.sv =====
// ----------------------------------------------------------------------------
// binomial_coefficient_mod_prime
// C(n,k) mod 1000000007 answered from factorial and inverse-factorial tables.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one query (n, k) per item; the rsp_ channel
//   returns one item holding the coefficient and an invalid flag. An item
//   moves when valid is high and stall is low.
//   After reset the block builds both tables: the factorials first, then the
//   Fermat inverse of the top entry, then the downward recurrence for the
//   inverse factorials. req_stall stays high throughout.
//   Once built, a query passes one table read, then two four-stage modular
//   multipliers in series, before it reaches the output queue. One item is
//   accepted every cycle while req_stall is low. A 16-entry result queue
//   with credit counting absorbs a stalled receiver; when it is full,
//   req_stall rises.
//   k above n or n outside the table gives coefficient 0 and invalid 1.
// ----------------------------------------------------------------------------
module binomial_coefficient_mod_prime
   import bcmp_pkg::*;
#(
   parameter int TABLE_SIZE = DEF_TABLE_SIZE
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [QW-1:0] req_query_n,
   input  logic [QW-1:0] req_query_k,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [CW-1:0] rsp_coefficient,
   output logic          rsp_invalid_query
);

   localparam int AW       = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int EW       = (AW > QW) ? AW : QW;
   localparam int PIPE_LAT = 1 + 2 * MUL_LAT;
   localparam int QDEPTH   = 16;
   localparam int QPW      = $clog2(QDEPTH);

   // table memories
   logic [CW-1:0] fact_mem [TABLE_SIZE];
   logic [CW-1:0] inv_mem  [TABLE_SIZE];

   // build sequencer
   bld_state_type state_ff, state_in;
   logic [CW-1:0] acc_ff, acc_in;
   logic [CW-1:0] sq_ff, sq_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [4:0]    bit_ff, bit_in;
   logic [1:0]    wcnt_ff, wcnt_in;
   logic          ready_ff;
   logic          wait_done;
   logic          last_idx;

   logic          fact_we, inv_we;
   logic [AW-1:0] fact_wa, inv_wa;
   logic [CW-1:0] fact_wd, inv_wd;
   logic [CW-1:0] bld_a, bld_b;

   // query path
   logic          req_acc, rsp_acc;
   logic [EW-1:0] n_w, k_w, nk_w;
   logic [QW-1:0] nk;
   logic          q_bad;
   logic [CW-1:0] fact_rd_ff, invk_rd_ff, invnk_rd_ff;
   logic [CW-1:0] nk_dly_ff [MUL_LAT];
   logic [PIPE_LAT-1:0] vld_ff;
   logic [PIPE_LAT-1:0] bad_ff;
   logic [CW-1:0] mul_a_x, mul_a_y, mul_a_r;
   logic [CW-1:0] mul_b_x, mul_b_y, mul_b_r;

   // result queue
   logic [CW-1:0]  qval_mem [QDEPTH];
   logic           qbad_mem [QDEPTH];
   logic [QPW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPW:0]   qcnt_ff;
   logic [QPW:0]   credit_ff;

   // build sequencer: next state
   assign wait_done = (wcnt_ff == 2'(MUL_LAT - 1));
   assign last_idx  = (idx_ff == AW'(TABLE_SIZE - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:      state_in = ST_FACT_MUL;
         ST_FACT_MUL:  state_in = ST_FACT_WAIT;
         ST_FACT_WAIT: begin
            if (wait_done) begin
               state_in = last_idx ? ST_POW_MUL : ST_FACT_MUL;
            end
         end
         ST_POW_MUL:   state_in = ST_POW_WAIT;
         ST_POW_WAIT:  begin
            if (wait_done) begin
               state_in = (bit_ff == 5'(CW - 1)) ? ST_INV_MUL : ST_POW_MUL;
            end
         end
         ST_INV_MUL:   state_in = ST_INV_WAIT;
         ST_INV_WAIT:  begin
            if (wait_done) begin
               state_in = (idx_ff == AW'(1)) ? ST_DONE : ST_INV_MUL;
            end
         end
         ST_DONE:      state_in = ST_DONE;
         default:      state_in = ST_INIT;
      endcase
   end

   // build sequencer: outputs and working registers
   always_comb begin
      acc_in  = acc_ff;
      sq_in   = sq_ff;
      idx_in  = idx_ff;
      bit_in  = bit_ff;
      wcnt_in = 2'd0;
      fact_we = 1'b0;
      fact_wa = idx_ff;
      fact_wd = mul_a_r;
      inv_we  = 1'b0;
      inv_wa  = idx_ff;
      inv_wd  = mul_a_r;
      bld_a   = acc_ff;
      bld_b   = (state_ff == ST_POW_MUL) ? sq_ff : CW'(idx_ff);
      case (state_ff)
         ST_INIT: begin
            fact_we = 1'b1;
            fact_wa = '0;
            fact_wd = CW'(1);
            acc_in  = CW'(1);
            idx_in  = AW'(1);
         end
         ST_FACT_WAIT: begin
            wcnt_in = wcnt_ff + 2'd1;
            if (wait_done) begin
               fact_we = 1'b1;
               acc_in  = mul_a_r;
               if (last_idx) begin
                  sq_in  = mul_a_r;
                  acc_in = CW'(1);
                  bit_in = '0;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         ST_POW_WAIT: begin
            wcnt_in = wcnt_ff + 2'd1;
            if (wait_done) begin
               sq_in = mul_b_r;
               if (FERMAT_EXP[bit_ff]) begin
                  acc_in = mul_a_r;
               end
               bit_in = bit_ff + 5'd1;
               if (bit_ff == 5'(CW - 1)) begin
                  inv_we = 1'b1;
                  inv_wa = AW'(TABLE_SIZE - 1);
                  inv_wd = FERMAT_EXP[bit_ff] ? mul_a_r : acc_ff;
                  idx_in = AW'(TABLE_SIZE - 1);
               end
            end
         end
         ST_INV_WAIT: begin
            wcnt_in = wcnt_ff + 2'd1;
            if (wait_done) begin
               inv_we = 1'b1;
               inv_wa = idx_ff - AW'(1);
               acc_in = mul_a_r;
               idx_in = idx_ff - AW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         wcnt_ff  <= 2'd0;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wcnt_ff  <= wcnt_in;
         ready_ff <= (state_in == ST_DONE);
      end
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      idx_ff <= idx_in;
      bit_ff <= bit_in;
   end

   // handshake and query decode
   assign req_stall = !ready_ff || (credit_ff == (QPW + 1)'(QDEPTH));
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = (qcnt_ff != '0);
   assign rsp_acc   = rsp_valid && !rsp_stall;

   assign nk    = req_query_n - req_query_k;
   assign n_w   = EW'(req_query_n);
   assign k_w   = EW'(req_query_k);
   assign nk_w  = EW'(nk);
   assign q_bad = (req_query_k > req_query_n) ||
                  (32'(req_query_n) >= 32'(TABLE_SIZE));

   // table memories: build writes, query reads
   always_ff @(posedge clock) begin
      if (fact_we) begin
         fact_mem[fact_wa] <= fact_wd;
      end
      fact_rd_ff <= fact_mem[n_w[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (inv_we) begin
         inv_mem[inv_wa] <= inv_wd;
      end
      invk_rd_ff  <= inv_mem[k_w[AW-1:0]];
      invnk_rd_ff <= inv_mem[nk_w[AW-1:0]];
   end

   // multipliers, borrowed by the build sequencer until ready
   assign mul_a_x = ready_ff ? fact_rd_ff : bld_a;
   assign mul_a_y = ready_ff ? invk_rd_ff : bld_b;
   assign mul_b_x = ready_ff ? mul_a_r : sq_ff;
   assign mul_b_y = ready_ff ? nk_dly_ff[MUL_LAT-1] : sq_ff;

   bcmp_modmul u_mul_a (
      .clock  (clock),
      .op_a   (mul_a_x),
      .op_b   (mul_a_y),
      .result (mul_a_r)
   );

   bcmp_modmul u_mul_b (
      .clock  (clock),
      .op_a   (mul_b_x),
      .op_b   (mul_b_y),
      .result (mul_b_r)
   );

   // align the (n-k) inverse with the first product
   always_ff @(posedge clock) begin
      nk_dly_ff[0] <= invnk_rd_ff;
      for (int i = 1; i < MUL_LAT; i++) begin
         nk_dly_ff[i] <= nk_dly_ff[i-1];
      end
   end

   // item tracking along the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_acc};
      end
      bad_ff <= {bad_ff[PIPE_LAT-2:0], q_bad};
   end

   // result queue
   always_ff @(posedge clock) begin
      if (vld_ff[PIPE_LAT-1]) begin
         qval_mem[wr_ptr_ff] <= bad_ff[PIPE_LAT-1] ? '0 : mul_b_r;
         qbad_mem[wr_ptr_ff] <= bad_ff[PIPE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         qcnt_ff   <= '0;
         credit_ff <= '0;
      end else begin
         if (vld_ff[PIPE_LAT-1]) begin
            wr_ptr_ff <= wr_ptr_ff + QPW'(1);
         end
         if (rsp_acc) begin
            rd_ptr_ff <= rd_ptr_ff + QPW'(1);
         end
         qcnt_ff   <= qcnt_ff + (QPW + 1)'(vld_ff[PIPE_LAT-1])
                              - (QPW + 1)'(rsp_acc);
         credit_ff <= credit_ff + (QPW + 1)'(req_acc) - (QPW + 1)'(rsp_acc);
      end
   end

   assign rsp_coefficient   = qval_mem[rd_ptr_ff];
   assign rsp_invalid_query = qbad_mem[rd_ptr_ff];

endmodule

// ===== bench/binomial_coefficient_mod_prime_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_coefficient_mod_prime_tb
// Drives queries (n, k) into the binomial coefficient block and checks each
// answer against an own factorial-table predictor, under several idling
// phases on both channels, after the start-up table build.
// ----------------------------------------------------------------------------
module binomial_coefficient_mod_prime_tb;
   import bcmp_pkg::*;

   localparam int TBL = DEF_TABLE_SIZE;
   localparam longint P = 64'd1000000007;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [QW-1:0] req_query_n = '0;
   logic [QW-1:0] req_query_k = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [CW-1:0] rsp_coefficient;
   logic          rsp_invalid_query;

   typedef struct packed {
      logic [CW-1:0] coefficient;
      logic          invalid_query;
   } answer_type;

   answer_type answers_due[$];
   longint    fact_mod[TBL];
   longint    inv_fact_mod[TBL];
   int        mismatches = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;

   binomial_coefficient_mod_prime i_dut (.*);

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   // factorial tables for the predictor
   function automatic longint power_mod(longint base, longint ex);
      longint acc;
      acc = 1;
      base = base % P;
      while (ex != 0) begin
         if (ex[0]) acc = (acc * base) % P;
         base = (base * base) % P;
         ex = ex >> 1;
      end
      return acc;
   endfunction

   function automatic answer_type binomial_answer(logic [QW-1:0] n, logic [QW-1:0] k);
      answer_type a;
      a.coefficient = '0;
      a.invalid_query = 1'b1;
      if (k <= n && int'(n) < TBL) begin
         a.coefficient = CW'((((fact_mod[n] * inv_fact_mod[k]) % P)
                              * inv_fact_mod[n - k]) % P);
         a.invalid_query = 1'b0;
      end
      return a;
   endfunction

   // append one predicted answer to the tail of the queue
   function automatic void queue_answer(answer_type a);
      answers_due = {answers_due, a};
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // result checking
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            report_mismatch("unexpected item", rsp_coefficient, 0);
         end else begin
            want = answers_due.pop_front();
            if (rsp_coefficient !== want.coefficient)
               report_mismatch("coefficient", rsp_coefficient, want.coefficient);
            if (rsp_invalid_query !== want.invalid_query)
               report_mismatch("invalid_query", rsp_invalid_query,
                               want.invalid_query);
         end
      end
   end

   // send one query item; valid stays high until the caller idles or drains
   task automatic send_query(logic [QW-1:0] n, logic [QW-1:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_query_n <= n;
      req_query_k <= k;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      queue_answer(binomial_answer(n, k));
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   // extremes, k above n, and n at table edge
   task automatic test_directed();
      send_query(12'd0, 12'd0);
      send_query(12'd1, 12'd0);
      send_query(12'd1, 12'd1);
      send_query(12'd4095, 12'd0);
      send_query(12'd4095, 12'd4095);
      send_query(12'd4095, 12'd2047);
      send_query(12'd4095, 12'd1);
      send_query(12'd4094, 12'd2047);
      send_query(12'd0, 12'd4095);
      send_query(12'd5, 12'd6);
      send_query(12'd2048, 12'd4095);
      send_query(12'd10, 12'd5);
      send_query(12'hAAA, 12'h555);
      send_query(12'h555, 12'hAAA);
      send_query(12'd4095, 12'd4094);
      drain_answers();
   endtask

   // random queries, mostly valid ones
   task automatic test_random(int count);
      logic [QW-1:0] n, k;
      repeat (count) begin
         n = QW'($urandom_range(4095));
         if ($urandom_range(9) < 8) k = QW'($urandom_range(n));
         else k = QW'($urandom_range(4095));
         send_query(n, k);
      end
      drain_answers();
   endtask

   initial begin
      fact_mod[0] = 1;
      for (int i = 1; i < TBL; i++) fact_mod[i] = (fact_mod[i-1] * i) % P;
      inv_fact_mod[TBL-1] = power_mod(fact_mod[TBL-1], P - 2);
      for (int i = TBL - 1; i > 0; i--)
         inv_fact_mod[i-1] = (inv_fact_mod[i] * i) % P;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(250);
      send_idle_pct = 61;
      test_random(200);
      send_idle_pct = 0;
      recv_stall_pct = 61;
      test_random(250);
      send_idle_pct = 11;
      recv_stall_pct = 11;
      test_random(200);
      recv_stall_pct = 0;
      repeat (20) @(posedge clock);
      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
